// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property check failed");

// Condition that must never be seen at a clock edge outside reset.
`define CHK_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

// ===== sv/stflr_pkg.sv =====
// Shared types and constants of the strip/fan to triangle list remapper.
package stflr_pkg;

    localparam int POINT_W     = 12;
    localparam int SLOT_W      = 12;
    localparam int COUNT_W     = 13;
    localparam int SLOT_LIMIT  = 4096;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 2;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (POINT_W + 4 * SLOT_W + COUNT_W);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // One polygon corner as it arrives
    typedef struct packed {
        logic               strip_mode;
        logic               surface_start;
        logic               polygon_start;
        logic [POINT_W-1:0] point_index;
    } point_item_t;

    // One result item
    typedef struct packed {
        logic [COUNT_W-1:0] vertex_count;
        logic [SLOT_W-1:0]  tri_third;
        logic [SLOT_W-1:0]  tri_second;
        logic [SLOT_W-1:0]  tri_first;
        logic               tri_valid;
        logic [SLOT_W-1:0]  vertex_slot;
        logic [POINT_W-1:0] vertex_source;
        logic               vertex_new;
    } result_t;

endpackage

// ===== sv/stflr_front.sv =====
// Front end: accepts corners and reduces each point index to a remap table entry.
module stflr_front #(
    parameter int MAX_POINTS = 4096,
    parameter int ENTRY_W    = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  stflr_pkg::point_item_t        in_item,
    input  logic [stflr_pkg::QCNT_W-1:0]  q_count,
    output logic                          push,
    output stflr_pkg::point_item_t        push_item,
    output logic [ENTRY_W-1:0]            push_entry
);

    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = (1 << RECIP_SHIFT) / MAX_POINTS;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int MOD_W       = $clog2(MAX_POINTS + 1);
    localparam int REM_W       = ((MOD_W > stflr_pkg::POINT_W) ? MOD_W : stflr_pkg::POINT_W) + 1;
    localparam int PROD_W      = stflr_pkg::POINT_W + RECIP_W;
    localparam int QM_W        = stflr_pkg::POINT_W + MOD_W;
    localparam int FLY_W       = stflr_pkg::QCNT_W + 1;

    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);
    localparam logic [MOD_W-1:0]   MOD_K   = MOD_W'(MAX_POINTS);
    localparam logic [REM_W-1:0]   MOD_R   = REM_W'(MAX_POINTS);

    logic                                accept;
    logic [PROD_W-1:0]                   prod;
    logic [stflr_pkg::POINT_W-1:0]       quot_next;
    logic [QM_W-1:0]                     qm_full;
    logic [stflr_pkg::POINT_W-1:0]       qm_next;
    logic [REM_W-1:0]                    rem_raw;
    logic [REM_W-1:0]                    rem;
    logic [FLY_W-1:0]                    in_flight;

    logic                                f1_valid_reg;
    logic                                f2_valid_reg;
    stflr_pkg::point_item_t              f1_item_reg;
    stflr_pkg::point_item_t              f2_item_reg;
    logic [stflr_pkg::POINT_W-1:0]       quot_reg;
    logic [stflr_pkg::POINT_W-1:0]       qm_reg;

    // Take a transfer only while the queue has room for everything in flight
    assign in_flight = FLY_W'(q_count) + FLY_W'(f1_valid_reg) + FLY_W'(f2_valid_reg);
    assign in_ready  = in_flight < FLY_W'(stflr_pkg::QUEUE_DEPTH);
    assign accept    = in_valid & in_ready;

    // Quotient estimate by reciprocal; low by at most one
    assign prod      = in_item.point_index * RECIP_K;
    assign quot_next = stflr_pkg::POINT_W'(prod >> RECIP_SHIFT);

    // Quotient times MAX_POINTS, never above the point index
    assign qm_full = quot_reg * MOD_K;
    assign qm_next = stflr_pkg::POINT_W'(qm_full);

    // Remainder with one correction step
    always_comb
    begin
        rem_raw = REM_W'(f2_item_reg.point_index) - REM_W'(qm_reg);
        if (rem_raw >= MOD_R)
        begin
            rem = rem_raw - MOD_R;
        end
        else
        begin
            rem = rem_raw;
        end
    end

    assign push       = f2_valid_reg;
    assign push_item  = f2_item_reg;
    assign push_entry = ENTRY_W'(rem);

    // Advance the stage valids every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    // Carry the payload along
    always_ff @(posedge clk)
    begin
        f1_item_reg <= in_item;
        quot_reg    <= quot_next;
        f2_item_reg <= f1_item_reg;
        qm_reg      <= qm_next;
    end

endmodule

// ===== sv/stflr_queue.sv =====
// Short FIFO that decouples the front end from the remap back end.
module stflr_queue #(
    parameter int WIDTH = 27
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [WIDTH-1:0]              push_data,
    input  logic                          pop,
    output logic [WIDTH-1:0]              head_data,
    output logic [stflr_pkg::QCNT_W-1:0]  count
);

    logic [WIDTH-1:0]              slots_reg [stflr_pkg::QUEUE_DEPTH];
    logic [stflr_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [stflr_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [stflr_pkg::QCNT_W-1:0]  count_reg;
    logic [stflr_pkg::QCNT_W-1:0]  count_next;

    assign head_data = slots_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Move the pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/stflr_back.sv =====
// Back end: remap lookup and update, polygon assembly and output register.
module stflr_back #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           head_valid,
    input  stflr_pkg::point_item_t         head_item,
    input  logic [$clog2(TABLE_DEPTH)-1:0] head_entry,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output stflr_pkg::result_t             out_result
);

    localparam int ENTRY_W = $clog2(TABLE_DEPTH);
    localparam int SLOT_W  = stflr_pkg::SLOT_W;
    localparam int COUNT_W = stflr_pkg::COUNT_W;

    // Corner phase codes
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_EMIT   = 2'd2;

    // Remap memories: entry to slot, and slot back to its owning entry
    logic [ENTRY_W-1:0] tab_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] own_mem [TABLE_DEPTH];

    logic                   fire;
    logic                   adv2;

    logic                   v1_reg;
    logic                   v2_reg;
    logic                   out_valid_reg;
    stflr_pkg::point_item_t it1_reg;
    stflr_pkg::point_item_t it2_reg;
    logic [ENTRY_W-1:0]     e1_reg;
    logic [ENTRY_W-1:0]     e2_reg;
    logic [ENTRY_W-1:0]     tab_rd_reg;
    logic [ENTRY_W-1:0]     tab2_reg;
    logic [ENTRY_W-1:0]     own_rd_reg;
    stflr_pkg::result_t     out_result_reg;

    // Polygon and surface state
    logic [COUNT_W-1:0]     next_slot_reg;
    logic [COUNT_W-1:0]     next_slot_next;
    logic [SLOT_W-1:0]      held_one_reg;
    logic [SLOT_W-1:0]      held_one_next;
    logic [SLOT_W-1:0]      held_two_reg;
    logic [SLOT_W-1:0]      held_two_next;
    logic [1:0]             phase_reg;
    logic [1:0]             phase_next;
    logic                   parity_reg;
    logic                   parity_next;
    logic                   mode_reg;

    // Records of the last two retired items, for updates the reads missed
    logic                   p1_valid_reg;
    logic                   p2_valid_reg;
    logic [ENTRY_W-1:0]     p1_entry_reg;
    logic [ENTRY_W-1:0]     p2_entry_reg;
    logic [ENTRY_W-1:0]     p1_slot_reg;
    logic [ENTRY_W-1:0]     p2_slot_reg;
    logic                   p1_new_reg;
    logic                   p2_new_reg;
    logic                   p1_surf_reg;

    logic                   sst;
    logic                   pst;
    logic                   mode;
    logic [1:0]             phase;
    logic                   parity;
    logic [COUNT_W-1:0]     next_base;
    logic                   hit;
    logic [ENTRY_W-1:0]     found;
    logic                   is_new;
    logic [SLOT_W-1:0]      slot;
    logic [ENTRY_W-1:0]     slot_ew;
    stflr_pkg::result_t     result;

    // Pipeline flow
    assign fire = v2_reg && (!out_valid_reg || out_ready);
    assign adv2 = v1_reg && (!v2_reg || fire);
    assign pop  = head_valid && (!v1_reg || adv2);

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    // Start-of-polygon and start-of-surface overrides
    assign sst       = it2_reg.surface_start;
    assign pst       = it2_reg.polygon_start | sst;
    assign mode      = pst ? it2_reg.strip_mode : mode_reg;
    assign phase     = pst ? PH_FIRST : phase_reg;
    assign parity    = pst ? 1'b0 : parity_reg;
    assign next_base = sst ? '0 : next_slot_reg;

    // Decide whether the point already has a slot in this surface
    always_comb
    begin
        hit   = 1'b0;
        found = '0;
        if (sst)
        begin
            hit = 1'b0;
        end
        else if (p1_valid_reg && (p1_entry_reg == e2_reg))
        begin
            hit   = 1'b1;
            found = p1_slot_reg;
        end
        else if (p2_valid_reg && (p2_entry_reg == e2_reg))
        begin
            hit   = !(p1_valid_reg && p1_surf_reg);
            found = p2_slot_reg;
        end
        else if ((COUNT_W'(tab2_reg) < next_slot_reg) && (own_rd_reg == e2_reg)
                 && !(p1_valid_reg && p1_new_reg && (p1_slot_reg == tab2_reg))
                 && !(p2_valid_reg && p2_new_reg && (p2_slot_reg == tab2_reg)))
        begin
            hit   = 1'b1;
            found = tab2_reg;
        end
    end

    assign is_new  = !hit;
    assign slot    = hit ? SLOT_W'(found) : next_base[SLOT_W-1:0];
    assign slot_ew = ENTRY_W'(slot);

    // Saturating slot counter
    always_comb
    begin
        next_slot_next = next_base;
        if (is_new && (next_base < COUNT_W'(stflr_pkg::SLOT_LIMIT)))
        begin
            next_slot_next = next_base + 1'b1;
        end
    end

    // Corner sequencing and triangle assembly
    always_comb
    begin
        held_one_next     = held_one_reg;
        held_two_next     = held_two_reg;
        phase_next        = phase;
        parity_next       = parity;
        result            = '0;
        result.vertex_new = is_new;
        if (is_new)
        begin
            result.vertex_source = it2_reg.point_index;
        end
        result.vertex_slot  = slot;
        result.vertex_count = next_slot_next;
        case (phase)
            PH_FIRST:
            begin
                held_one_next = slot;
                phase_next    = PH_SECOND;
            end
            PH_SECOND:
            begin
                held_two_next = slot;
                phase_next    = PH_EMIT;
                parity_next   = 1'b0;
            end
            default:
            begin
                result.tri_valid  = 1'b1;
                result.tri_first  = held_one_reg;
                result.tri_second = held_two_reg;
                result.tri_third  = slot;
                if (!mode || parity)
                begin
                    held_two_next = slot;
                end
                else
                begin
                    held_one_next = slot;
                end
                if (mode)
                begin
                    parity_next = !parity;
                end
                phase_next = PH_EMIT;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            next_slot_reg <= '0;
            held_one_reg  <= '0;
            held_two_reg  <= '0;
            phase_reg     <= PH_FIRST;
            parity_reg    <= 1'b0;
            mode_reg      <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                v1_reg <= 1'b1;
            end
            else if (adv2)
            begin
                v1_reg <= 1'b0;
            end
            if (adv2)
            begin
                v2_reg <= 1'b1;
            end
            else if (fire)
            begin
                v2_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                next_slot_reg <= next_slot_next;
                held_one_reg  <= held_one_next;
                held_two_reg  <= held_two_next;
                phase_reg     <= phase_next;
                parity_reg    <= parity_next;
                mode_reg      <= mode;
                p1_valid_reg  <= 1'b1;
                p2_valid_reg  <= p1_valid_reg;
            end
        end
    end

    // Stage payloads, retired-item records and output data
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            it1_reg <= head_item;
            e1_reg  <= head_entry;
        end
        if (adv2)
        begin
            it2_reg  <= it1_reg;
            e2_reg   <= e1_reg;
            tab2_reg <= tab_rd_reg;
        end
        if (fire)
        begin
            out_result_reg <= result;
            p1_entry_reg   <= e2_reg;
            p1_slot_reg    <= slot_ew;
            p1_new_reg     <= is_new;
            p1_surf_reg    <= sst;
            p2_entry_reg   <= p1_entry_reg;
            p2_slot_reg    <= p1_slot_reg;
            p2_new_reg     <= p1_new_reg;
        end
    end

    // Entry-to-slot memory: read on entry to the first stage, write on retire of a new vertex
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tab_rd_reg <= tab_mem[head_entry];
        end
        if (fire && is_new)
        begin
            tab_mem[e2_reg] <= slot_ew;
        end
    end

    // Slot-to-owner memory: read with the slot just fetched, write on retire of a new vertex
    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            own_rd_reg <= own_mem[tab_rd_reg];
        end
        if (fire && is_new)
        begin
            own_mem[slot_ew] <= e2_reg;
        end
    end

endmodule

// ===== sv/strip_fan_to_triangle_list_remap.sv =====
// A result passes stages f1, f2, the queue, the back stages and the output register.
// Throughput: one corner per cycle unless stalled; each corner does one remap table
// read and one owner read, pipelined, and a new vertex writes both at retire.
// Reset clears all control state and the slot counter; the remap memories are not
// swept, since an entry counts as valid only when its slot and owner agree.
module strip_fan_to_triangle_list_remap #(
    parameter int MAX_POINTS = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [11:0] point_index, [15:12] zero
    input  logic [stflr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] polygon_start, [1] surface_start, [2] strip_mode
    input  logic [stflr_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [11:0] vertex_source, [23:12] vertex_slot, [35:24] tri_first,
    // [47:36] tri_second, [59:48] tri_third, [72:60] vertex_count, [79:73] zero
    output logic [stflr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [0] vertex_new, [1] tri_valid
    output logic [stflr_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

    localparam int TABLE_DEPTH = (MAX_POINTS < stflr_pkg::SLOT_LIMIT) ?
                                 MAX_POINTS : stflr_pkg::SLOT_LIMIT;
    localparam int ENTRY_W     = $clog2(TABLE_DEPTH);
    localparam int ITEM_W      = $bits(stflr_pkg::point_item_t);
    localparam int QUEUE_W     = ENTRY_W + ITEM_W;

    stflr_pkg::point_item_t          in_item;
    stflr_pkg::point_item_t          push_item;
    stflr_pkg::point_item_t          head_item;
    logic [ENTRY_W-1:0]              push_entry;
    logic [ENTRY_W-1:0]              head_entry;
    logic                            push;
    logic                            pop;
    logic [QUEUE_W-1:0]              head_data;
    logic [stflr_pkg::QCNT_W-1:0]    q_count;
    stflr_pkg::result_t              result;

    // Unpack the incoming transfer
    assign in_item.point_index   = s_axis_tdata[stflr_pkg::POINT_W-1:0];
    assign in_item.polygon_start = s_axis_tuser[0];
    assign in_item.surface_start = s_axis_tuser[1];
    assign in_item.strip_mode    = s_axis_tuser[2];

    stflr_front #(
        .MAX_POINTS (MAX_POINTS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .q_count    (q_count),
        .push       (push),
        .push_item  (push_item),
        .push_entry (push_entry)
    );

    stflr_queue #(
        .WIDTH (QUEUE_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_entry, push_item}),
        .pop       (pop),
        .head_data (head_data),
        .count     (q_count)
    );

    assign head_entry = head_data[QUEUE_W-1:ITEM_W];
    assign head_item  = head_data[ITEM_W-1:0];

    stflr_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_count != '0),
        .head_item  (head_item),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    // Pack the outgoing transfer
    assign m_axis_tdata = {{stflr_pkg::OUT_PAD_W{1'b0}},
                           result.vertex_count,
                           result.tri_third,
                           result.tri_second,
                           result.tri_first,
                           result.vertex_slot,
                           result.vertex_source};
    assign m_axis_tuser = {result.tri_valid, result.vertex_new};

endmodule

// ===== sv/stflr_checker.sv =====
// Port-level checks on the remapper output stream, bound to the top level.
`include "assert_macros.svh"

module stflr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser
);

    // Hold a stalled output transfer
    `CHK_ASSERT(a_out_hold, clk, rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))

    // A triangle ends on the current corner's slot
    `CHK_ASSERT(a_tri_third, clk, rst_n, (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[59:48] == m_axis_tdata[23:12]))

    // A new vertex takes the last slot counted
    `CHK_ASSERT(a_new_slot, clk, rst_n, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[23:12] == 12'(m_axis_tdata[72:60] - 13'd1)))

    // Without a triangle the triangle fields stay zero
    `CHK_NEVER(a_tri_idle, clk, rst_n, m_axis_tvalid && !m_axis_tuser[1] && (m_axis_tdata[59:24] != 36'd0))

endmodule

bind strip_fan_to_triangle_list_remap stflr_checker u_stflr_checker (.*);

// ===== tb/tb_strip_fan_to_triangle_list_remap.sv =====
// Self-checking testbench for the strip/fan to triangle list remapper.
module tb_strip_fan_to_triangle_list_remap;

    localparam int  CYCLE_LIMIT   = 200000;
    localparam int  DRAIN_CYCLES  = 12;
    localparam int  IDLE_PERCENT  = 32;
    localparam int  REPORT_LIMIT  = 10;
    localparam int  TABLE_DEPTH   = 4096;
    localparam int  SWEEP_POINTS  = 640;
    localparam int  RANDOM_ITEMS  = 930;
    localparam int  DUE_DEPTH     = 64;

    localparam logic MODE_FAN     = 1'b0;
    localparam logic MODE_STRIP   = 1'b1;

    typedef enum logic [1:0] {
        AWAIT_FIRST  = 2'd0,
        AWAIT_SECOND = 2'd1,
        EMITTING     = 2'd2
    } corner_phase_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [stflr_pkg::IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic [stflr_pkg::IN_TUSER_W-1:0]    s_axis_tuser = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [stflr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic [stflr_pkg::OUT_TUSER_W-1:0]   m_axis_tuser;

    // Remap predictor state
    logic [stflr_pkg::SLOT_W-1:0]        slot_map [TABLE_DEPTH];
    bit                                  point_seen [TABLE_DEPTH];
    logic [stflr_pkg::COUNT_W-1:0]       slots_used = '0;
    logic [stflr_pkg::SLOT_W-1:0]        held_a = '0;
    logic [stflr_pkg::SLOT_W-1:0]        held_b = '0;
    corner_phase_t                       phase = AWAIT_FIRST;
    logic                                parity = 1'b0;
    logic                                poly_mode = MODE_FAN;

    // Expected results in transfer order, as a ring indexed by running counts
    stflr_pkg::result_t                  due_ring [DUE_DEPTH];
    int                                  due_wr = 0;
    int                                  due_rd = 0;
    int                                  result_errors = 0;
    int                                  cycle_count = 0;
    bit                                  steady = 1'b0;

    strip_fan_to_triangle_list_remap dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predict the result of one accepted corner and advance the remap state
    function automatic stflr_pkg::result_t remap_corner(input stflr_pkg::point_item_t item);
        stflr_pkg::result_t           r;
        logic                         poly_start;
        logic [stflr_pkg::SLOT_W-1:0] slot;
        r = '0;
        poly_start = item.polygon_start;
        if (item.surface_start)
        begin
            foreach (point_seen[i])
                point_seen[i] = 1'b0;
            slots_used = '0;
            poly_start = 1'b1;
        end
        if (poly_start)
        begin
            poly_mode = item.strip_mode;
            phase = AWAIT_FIRST;
            parity = 1'b0;
        end
        // Look up the point, assigning the next slot on first sight
        if (point_seen[item.point_index])
            slot = slot_map[item.point_index];
        else
        begin
            slot = slots_used[stflr_pkg::SLOT_W-1:0];
            slot_map[item.point_index] = slot;
            point_seen[item.point_index] = 1'b1;
            if (slots_used < stflr_pkg::SLOT_LIMIT)
                slots_used = slots_used + 1'b1;
            r.vertex_new = 1'b1;
            r.vertex_source = item.point_index;
        end
        r.vertex_slot = slot;
        case (phase)
            AWAIT_FIRST:
            begin
                held_a = slot;
                phase = AWAIT_SECOND;
            end
            AWAIT_SECOND:
            begin
                held_b = slot;
                phase = EMITTING;
                parity = 1'b0;
            end
            default:
            begin
                r.tri_valid = 1'b1;
                r.tri_first = held_a;
                r.tri_second = held_b;
                r.tri_third = slot;
                // Fan keeps its first corner; strip replaces held corners in turn
                if (poly_mode == MODE_FAN || parity)
                    held_b = slot;
                else
                    held_a = slot;
                if (poly_mode == MODE_STRIP)
                    parity = ~parity;
                phase = EMITTING;
            end
        endcase
        r.vertex_count = slots_used;
        return r;
    endfunction

    // Print one mismatching result transfer
    function automatic void report_mismatch(input stflr_pkg::result_t want,
                                            input stflr_pkg::result_t got,
                                            input logic [stflr_pkg::OUT_PAD_W-1:0] pad);
        $display("expected new=%0d src=%0d slot=%0d tri=%0d (%0d %0d %0d) count=%0d",
                 want.vertex_new, want.vertex_source, want.vertex_slot,
                 want.tri_valid, want.tri_first, want.tri_second,
                 want.tri_third, want.vertex_count);
        $display("actual   new=%0d src=%0d slot=%0d tri=%0d (%0d %0d %0d) count=%0d pad=%0h",
                 got.vertex_new, got.vertex_source, got.vertex_slot,
                 got.tri_valid, got.tri_first, got.tri_second,
                 got.tri_third, got.vertex_count, pad);
    endfunction

    // Send one corner, idling at random unless steady, and record its expected result
    task automatic send_corner(input logic [stflr_pkg::POINT_W-1:0] point,
                               input logic poly_start,
                               input logic surf_start, input logic mode);
        stflr_pkg::point_item_t item;
        item.point_index = point;
        item.polygon_start = poly_start;
        item.surface_start = surf_start;
        item.strip_mode = mode;
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= stflr_pkg::IN_TDATA_W'(item.point_index);
        s_axis_tuser <= {item.strip_mode, item.surface_start, item.polygon_start};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        due_ring[due_wr % DUE_DEPTH] = remap_corner(item);
        due_wr++;
    endtask

    // First corners carry no polygon start: they form a fan whatever the mode bit says
    task automatic test_no_polygon_start();
        send_corner(12'd0, 1'b0, 1'b0, MODE_STRIP);
        send_corner(12'hFFF, 1'b0, 1'b0, MODE_STRIP);
        send_corner(12'd5, 1'b0, 1'b0, MODE_STRIP);
        send_corner(12'd6, 1'b0, 1'b0, MODE_FAN);
    endtask

    // Fans, strips, short polygons, repeated points and surface restarts
    task automatic test_polygon_shapes();
        // Fan on a new surface, reusing earlier points
        send_corner(12'hFFF, 1'b1, 1'b1, MODE_FAN);
        send_corner(12'd0, 1'b0, 1'b0, MODE_STRIP);
        send_corner(12'h800, 1'b0, 1'b0, MODE_STRIP);
        send_corner(12'd0, 1'b0, 1'b0, MODE_FAN);
        send_corner(12'h7FF, 1'b0, 1'b0, MODE_FAN);
        // Strip of six corners
        send_corner(12'd1, 1'b1, 1'b0, MODE_STRIP);
        send_corner(12'd2, 1'b0, 1'b0, MODE_FAN);
        send_corner(12'd3, 1'b0, 1'b0, MODE_FAN);
        send_corner(12'd4, 1'b0, 1'b0, MODE_STRIP);
        send_corner(12'hFFF, 1'b0, 1'b0, MODE_FAN);
        send_corner(12'd2, 1'b0, 1'b0, MODE_STRIP);
        // One-corner and two-corner polygons emit nothing
        send_corner(12'd9, 1'b1, 1'b0, MODE_STRIP);
        send_corner(12'd10, 1'b1, 1'b0, MODE_FAN);
        send_corner(12'd11, 1'b0, 1'b0, MODE_FAN);
        // Surface restart inside a polygon: its point becomes slot 0
        send_corner(12'd12, 1'b1, 1'b0, MODE_STRIP);
        send_corner(12'd11, 1'b0, 1'b1, MODE_STRIP);
        send_corner(12'd12, 1'b0, 1'b0, MODE_FAN);
        send_corner(12'd1, 1'b0, 1'b0, MODE_FAN);
        send_corner(12'd11, 1'b0, 1'b0, MODE_FAN);
    endtask

    // Sweep many distinct points in one surface with no idling on either side
    task automatic test_point_sweep();
        int                            base;
        int                            stride;
        logic                          mode;
        logic [stflr_pkg::POINT_W-1:0] point;
        base = $urandom_range(TABLE_DEPTH - 1);
        stride = 2 * $urandom_range(1, 1000) + 1;
        mode = MODE_FAN;
        steady = 1'b1;
        for (int i = 0; i < SWEEP_POINTS; i++)
        begin
            point = stflr_pkg::POINT_W'(base + i * stride);
            if (i % 6 == 0)
                mode = logic'($urandom_range(1));
            send_corner(point, i % 6 == 0, i == 0, mode);
        end
        steady = 1'b0;
        // Revisit points of the sweep: none is new and the count holds
        for (int i = 0; i < 8; i++)
        begin
            point = stflr_pkg::POINT_W'(base + int'($urandom_range(SWEEP_POINTS - 1)) * stride);
            send_corner(point, i == 0, 1'b0, MODE_STRIP);
        end
    endtask

    // Random surfaces of well-formed polygons over mostly small point pools, with some noise
    task automatic test_random_surfaces(input int n_items);
        int                            sent;
        int                            pool_base;
        int                            pool_size;
        int                            poly_len;
        bit                            first_in_surface;
        logic                          mode;
        logic                          poly_start;
        logic                          surf_start;
        logic [stflr_pkg::POINT_W-1:0] point;
        sent = 0;
        while (sent < n_items)
        begin
            pool_base = $urandom_range(TABLE_DEPTH - 1);
            pool_size = ($urandom_range(9) == 0) ? TABLE_DEPTH : $urandom_range(3, 48);
            first_in_surface = 1'b1;
            repeat ($urandom_range(1, 12))
            begin
                poly_len = $urandom_range(1, 10);
                mode = logic'($urandom_range(1));
                for (int k = 0; k < poly_len; k++)
                begin
                    point = stflr_pkg::POINT_W'(pool_base + $urandom_range(pool_size - 1));
                    poly_start = (k == 0);
                    surf_start = first_in_surface;
                    // Inject stray flags and far points now and then
                    if ($urandom_range(49) == 0)
                        poly_start = 1'b1;
                    if ($urandom_range(99) == 0)
                        surf_start = 1'b1;
                    if ($urandom_range(19) == 0)
                        point = stflr_pkg::POINT_W'($urandom);
                    send_corner(point, poly_start, surf_start,
                                (k == 0) ? mode : logic'($urandom_range(1)));
                    first_in_surface = 1'b0;
                    sent++;
                end
            end
        end
    endtask

    // Drive result-side backpressure
    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        stflr_pkg::result_t               got;
        stflr_pkg::result_t               want;
        logic [stflr_pkg::OUT_PAD_W-1:0]  pad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.vertex_new    = m_axis_tuser[0];
            got.tri_valid     = m_axis_tuser[1];
            got.vertex_source = m_axis_tdata[0 +: stflr_pkg::POINT_W];
            got.vertex_slot   = m_axis_tdata[stflr_pkg::POINT_W +: stflr_pkg::SLOT_W];
            got.tri_first     = m_axis_tdata[stflr_pkg::POINT_W + stflr_pkg::SLOT_W
                                             +: stflr_pkg::SLOT_W];
            got.tri_second    = m_axis_tdata[stflr_pkg::POINT_W + 2 * stflr_pkg::SLOT_W
                                             +: stflr_pkg::SLOT_W];
            got.tri_third     = m_axis_tdata[stflr_pkg::POINT_W + 3 * stflr_pkg::SLOT_W
                                             +: stflr_pkg::SLOT_W];
            got.vertex_count  = m_axis_tdata[stflr_pkg::POINT_W + 4 * stflr_pkg::SLOT_W
                                             +: stflr_pkg::COUNT_W];
            pad = m_axis_tdata[stflr_pkg::OUT_TDATA_W-1 -: stflr_pkg::OUT_PAD_W];
            if (due_rd == due_wr)
            begin
                result_errors++;
                if (result_errors <= REPORT_LIMIT)
                    $display("unexpected result transfer: slot=%0d count=%0d",
                             got.vertex_slot, got.vertex_count);
            end
            else
            begin
                want = due_ring[due_rd % DUE_DEPTH];
                due_rd++;
                if (got !== want || pad !== '0)
                begin
                    result_errors++;
                    if (result_errors <= REPORT_LIMIT)
                        report_mismatch(want, got, pad);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_polygon_start();
        test_polygon_shapes();
        test_point_sweep();
        test_random_surfaces(RANDOM_ITEMS);

        // Drain outstanding results, then let the pipeline settle
        s_axis_tvalid <= 1'b0;
        while (due_rd != due_wr)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (result_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
